// ===== hdl/pcrwm_pkg.sv =====
// Package for the per-channel running and window mean unit.
// Holds fixed widths, the controller state type and the stats record type.
// No dependencies.
package pcrwm_pkg;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned COUNT_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV_OV,
		ST_DIV_WM,
		ST_STEP,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0]  last;
		logic [DATA_W-1:0]  wmean;
		logic [DATA_W-1:0]  omean;
		logic [COUNT_W-1:0] count;
		logic [7:0]         head;
	} stats_t;

	localparam int unsigned STATS_W = $bits(stats_t);

	// Operation codes on the func field
	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

endpackage

// ===== hdl/pcrwm_if.sv =====
// Valid/ready channel interface for the per-channel mean unit.
// Carries a generic packed payload; depends on nothing.
interface pcrwm_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pcrwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcrwm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/pcrwm_div.sv =====
// Restoring serial divider: 64-bit dividend, 64-bit divisor, one bit a cycle.
// Depends on pcrwm_pkg.
module pcrwm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcrwm_pkg::DATA_W-1:0]  dividend,
	input  logic [pcrwm_pkg::DATA_W-1:0]  divisor,
	output logic                          done,
	output logic [pcrwm_pkg::DATA_W-1:0]  quotient
);
	import pcrwm_pkg::*;

	logic [DATA_W-1:0]      quo_q;
	logic [DATA_W:0]        rem_q;
	logic [DATA_W-1:0]      dsr_q;
	logic [$clog2(DATA_W):0] cnt_q;
	logic                   busy_q;
	logic [DATA_W:0]        shifted;
	logic [DATA_W:0]        diff;

	assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	// shift one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DATA_W)+1)'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_done_pulse: assert property (p_done_pulse) else $error("divider done held");

	property p_start_idle;
		@(posedge clk) disable iff (!arst_n) start |=> busy_q;
	endproperty
	a_start_idle: assert property (p_start_idle) else $error("divider did not start");
endmodule

// ===== hdl/per_channel_running_and_window_mean_unit.sv =====
// Per-channel running and window mean unit: top level.
// A read item, or an item for an out-of-range channel, goes from ST_READ and ST_LOAD to
// ST_OUT; a first update adds ST_WRITE; an update of a known channel with fewer than
// WINDOW_LEN readings makes two passes through the 64-step serial divider; with a full window
// it makes one serial pass plus a 4-step reciprocal multiply for the division by WINDOW_LEN.
// One item is in work at a time; a posted result waits in the output register while the
// next item is taken. Reset clears the control state and the per-channel valid bits; the
// stats and window memories are undefined until written and need no clearing.
module per_channel_running_and_window_mean_unit #(
	parameter int unsigned NUM_SENSORS = 256,
	parameter int unsigned WINDOW_LEN  = 10
) (
	input  logic clk,
	input  logic arst_n,
	pcrwm_if.sink   in_ch,
	pcrwm_if.source out_ch
);
	import pcrwm_pkg::*;

	// ceiling reciprocal 2^(DATA_W+ceil(log2 d))/d, exact for every DATA_W-bit dividend
	function automatic logic [DATA_W:0] window_recip(int unsigned d);
		logic [DATA_W+8:0] num;
		num = (DATA_W+9)'(1) << (DATA_W + $clog2(d));
		return (DATA_W+1)'((num + (DATA_W+9)'(d) - 1'b1) / (DATA_W+9)'(d));
	endfunction

	localparam int unsigned SID_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int unsigned WDEPTH = NUM_SENSORS * WINDOW_LEN;
	localparam int unsigned WADDR_W = $clog2(WDEPTH);
	localparam int unsigned HALF_W = DATA_W / 2;
	localparam int unsigned ACC_W = 2 * DATA_W + 8;
	localparam int unsigned WSHIFT = DATA_W + $clog2(WINDOW_LEN);
	localparam logic [DATA_W:0] WRECIP = window_recip(WINDOW_LEN);

	// input payload: {func, sensor_id, reading}
	logic              in_func;
	logic [ID_W-1:0]   in_id;
	logic [DATA_W-1:0] in_reading;
	assign {in_func, in_id, in_reading} = in_ch.data;

	state_t state_q, state_d;

	logic              func_q;
	logic [ID_W-1:0]   id_q;
	logic [DATA_W-1:0] reading_q;
	logic              inrange_q;
	logic              known_q;
	stats_t            st_q;
	logic [DATA_W-1:0] oldest_q;
	logic [DATA_W-1:0] oq_q;
	logic [DATA_W-1:0] wq_q;
	logic              wup_q;
	logic              oup_q;
	logic [NUM_SENSORS-1:0] valid_q;

	// output register
	logic                out_valid_q;
	logic                out_found_q;
	stats_t              out_st_q;
	logic                out_load;

	logic [SID_W-1:0] sid;
	assign sid = id_q[SID_W-1:0];

	// stats memory
	logic              st_we;
	stats_t            st_wdata;
	logic [STATS_W-1:0] st_rdata;
	stats_t            rd_st;
	logic              rd_up;

	pcrwm_ram #(.WIDTH(STATS_W), .DEPTH(NUM_SENSORS)) u_stats (
		.clk   (clk),
		.we    (st_we),
		.waddr (sid),
		.wdata (st_wdata),
		.raddr (sid),
		.rdata (st_rdata)
	);

	assign rd_st = stats_t'(st_rdata);
	assign rd_up = reading_q > rd_st.omean;

	// window sample memory
	logic               win_we;
	logic [WADDR_W-1:0] win_addr;
	logic [DATA_W-1:0]  win_rdata;
	logic [7:0]         head_use;

	always_comb begin
		head_use = (st_q.head >= 8'(WINDOW_LEN)) ? 8'd0 : st_q.head;
		if (!known_q) begin
			head_use = 8'd0;
		end
	end
	assign win_addr = WADDR_W'(32'(sid) * WINDOW_LEN + 32'(head_use));

	pcrwm_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_addr),
		.wdata (reading_q),
		.raddr (win_addr),
		.rdata (win_rdata)
	);

	// divider
	logic              div_start;
	logic [DATA_W-1:0] div_dividend;
	logic [DATA_W-1:0] div_divisor;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;

	pcrwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// division by WINDOW_LEN: reciprocal multiply, one 32x32 partial product a cycle
	logic              cdiv_start;
	logic [DATA_W-1:0] cd_x_q;
	logic [ACC_W-1:0]  cd_acc_q;
	logic [1:0]        cd_step_q;
	logic              cd_busy_q;
	logic              cd_done_q;
	logic [HALF_W-1:0] cd_a;
	logic [HALF_W-1:0] cd_b;
	logic [DATA_W-1:0] cd_prod;
	logic [ACC_W-1:0]  cd_pp;
	logic [DATA_W-1:0] cd_quo;

	assign cd_a    = cd_step_q[1] ? cd_x_q[DATA_W-1:HALF_W] : cd_x_q[HALF_W-1:0];
	assign cd_b    = cd_step_q[0] ? WRECIP[DATA_W-1:HALF_W] : WRECIP[HALF_W-1:0];
	assign cd_prod = DATA_W'(cd_a) * DATA_W'(cd_b);
	assign cd_quo  = cd_acc_q[WSHIFT +: DATA_W];

	// align the partial product to its weight
	always_comb begin
		case (cd_step_q)
			2'd0:    cd_pp = ACC_W'(cd_prod);
			2'd3:    cd_pp = ACC_W'(cd_prod) << DATA_W;
			default: cd_pp = ACC_W'(cd_prod) << HALF_W;
		endcase
	end

	// step through the four partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_busy_q <= 1'b0;
			cd_step_q <= '0;
			cd_done_q <= 1'b0;
		end else begin
			cd_done_q <= 1'b0;
			if (cdiv_start) begin
				cd_busy_q <= 1'b1;
				cd_step_q <= '0;
			end else if (cd_busy_q) begin
				cd_step_q <= cd_step_q + 2'd1;
				if (cd_step_q == 2'd3) begin
					cd_busy_q <= 1'b0;
					cd_done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate the product; the top reciprocal bit adds the dividend at 2^DATA_W
	always_ff @(posedge clk) begin
		if (cdiv_start) begin
			cd_x_q   <= div_dividend;
			cd_acc_q <= WRECIP[DATA_W] ? (ACC_W'(div_dividend) << DATA_W) : '0;
		end else if (cd_busy_q) begin
			cd_acc_q <= cd_acc_q + cd_pp;
		end
	end

	logic windowed;
	assign windowed = (st_q.count >= COUNT_W'(WINDOW_LEN));
	logic [DATA_W-1:0] div_cnt1;
	assign div_cnt1 = DATA_W'(st_q.count) + 1'b1;
	logic [DATA_W-1:0] wbase;
	assign wbase = windowed ? oldest_q : st_q.wmean;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	// next state and datapath controls
	always_comb begin
		state_d      = state_q;
		st_we        = 1'b0;
		win_we       = 1'b0;
		div_start    = 1'b0;
		cdiv_start   = 1'b0;
		div_dividend = '0;
		div_divisor  = div_cnt1;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!inrange_q || func_q == FUNC_READ) begin
					state_d = ST_OUT;
				end else if (!known_q) begin
					state_d = ST_WRITE;
				end else begin
					div_start = 1'b1;
					div_dividend = rd_up ? (reading_q - rd_st.omean)
						: (rd_st.omean - reading_q);
					div_divisor = DATA_W'(rd_st.count) + 1'b1;
					state_d = ST_DIV_OV;
				end
			end
			ST_DIV_OV: begin
				if (div_done) begin
					div_start = !windowed;
					cdiv_start = windowed;
					div_dividend = wup_q ? (reading_q - wbase) : (wbase - reading_q);
					state_d = ST_DIV_WM;
				end
			end
			ST_DIV_WM: begin
				if (windowed ? cd_done_q : div_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				st_we   = 1'b1;
				win_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// new record written back
	always_comb begin
		st_wdata = st_q;
		st_wdata.last = reading_q;
		if (!known_q) begin
			st_wdata.wmean = reading_q;
			st_wdata.omean = reading_q;
			st_wdata.count = COUNT_W'(1);
			st_wdata.head  = 8'(1 % WINDOW_LEN);
		end else begin
			st_wdata.head = (head_use == 8'(WINDOW_LEN - 1)) ? 8'd0 : head_use + 8'd1;
			if (st_q.count != '1) begin
				st_wdata.count = st_q.count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WRITE) begin
				valid_q[sid] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			func_q    <= in_func;
			id_q      <= in_id;
			reading_q <= in_reading;
			inrange_q <= (32'(in_id) < NUM_SENSORS);
		end
		if (state_q == ST_READ) begin
			known_q <= valid_q[sid];
		end
		if (state_q == ST_LOAD) begin
			st_q  <= rd_st;
			oup_q <= rd_up;
		end
		if (state_q == ST_DIV_OV) begin
			oldest_q <= win_rdata;
			wup_q    <= reading_q > (windowed ? win_rdata : st_q.wmean);
			if (div_done) begin
				oq_q <= div_quo;
			end
		end
		if (state_q == ST_DIV_WM && (windowed ? cd_done_q : div_done)) begin
			wq_q <= windowed ? cd_quo : div_quo;
		end
		if (state_q == ST_STEP) begin
			// saturating mean steps
			if (oup_q) begin
				st_q.omean <= (st_q.omean > ~oq_q) ? '1 : st_q.omean + oq_q;
			end else begin
				st_q.omean <= (st_q.omean < oq_q) ? '0 : st_q.omean - oq_q;
			end
			if (wup_q) begin
				st_q.wmean <= (st_q.wmean > ~wq_q) ? '1 : st_q.wmean + wq_q;
			end else begin
				st_q.wmean <= (st_q.wmean < wq_q) ? '0 : st_q.wmean - wq_q;
			end
		end
		if (state_q == ST_WRITE) begin
			st_q <= st_wdata;
		end
		if (out_load) begin
			out_found_q <= inrange_q && valid_q[sid];
			out_st_q    <= st_q;
		end
	end

	logic shown;
	assign shown = out_found_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = {shown,
		shown ? out_st_q.last  : DATA_W'(0),
		shown ? out_st_q.wmean : DATA_W'(0),
		shown ? out_st_q.omean : DATA_W'(0),
		shown ? out_st_q.count : COUNT_W'(0)};

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ch.ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

	property p_out_after_out;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_OUT) |=> out_valid_q;
	endproperty
	a_out_after_out: assert property (p_out_after_out) else $error("result lost");

	property p_write_once;
		@(posedge clk) disable iff (!arst_n) st_we |=> !st_we;
	endproperty
	a_write_once: assert property (p_write_once) else $error("double write");
endmodule

// ===== tb/sv/tb_per_channel_running_and_window_mean_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the per-channel running and window mean unit.
// Depends on pcrwm_pkg, pcrwm_if and the unit's top level; predicts every result itself.
module tb_per_channel_running_and_window_mean_unit;
	import pcrwm_pkg::*;

	localparam int unsigned CHANNELS  = 256;
	localparam int unsigned WIN       = 10;
	localparam int unsigned IN_W      = 1 + ID_W + DATA_W;
	localparam int unsigned OUT_W     = 1 + 3 * DATA_W + COUNT_W;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam logic [DATA_W-1:0] DATA_MAX = '1;

	typedef struct packed {
		logic               found;
		logic [DATA_W-1:0]  last_value;
		logic [DATA_W-1:0]  window_mean;
		logic [DATA_W-1:0]  overall_mean;
		logic [COUNT_W-1:0] sample_count;
	} stats_beat_t;

	logic clk;
	logic arst_n;

	pcrwm_if #(.W(IN_W))  in_if ();
	pcrwm_if #(.W(OUT_W)) out_if ();

	per_channel_running_and_window_mean_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	// Predicted channel state
	logic               chan_seen   [CHANNELS];
	logic [DATA_W-1:0]  chan_last   [CHANNELS];
	logic [DATA_W-1:0]  chan_wmean  [CHANNELS];
	logic [DATA_W-1:0]  chan_omean  [CHANNELS];
	logic [COUNT_W-1:0] chan_count  [CHANNELS];
	logic [DATA_W-1:0]  chan_window [CHANNELS][WIN];
	int unsigned        chan_head   [CHANNELS];

	stats_beat_t pending_stats[$];
	int          mismatches = 0;
	int          idle_cycles = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Move a mean toward target by |target-base|/div, clamped to the data range
	function automatic logic [DATA_W-1:0] step_mean(logic [DATA_W-1:0] mean,
			logic [DATA_W-1:0] target, logic [DATA_W-1:0] base, logic [DATA_W:0] div);
		logic [DATA_W:0] delta;
		logic [DATA_W:0] sum;
		if (target > base) begin
			delta = ({1'b0, target} - {1'b0, base}) / div;
			sum = {1'b0, mean} + delta;
			return sum[DATA_W] ? DATA_MAX : sum[DATA_W-1:0];
		end
		delta = ({1'b0, base} - {1'b0, target}) / div;
		return ({1'b0, mean} < delta) ? '0 : mean - delta[DATA_W-1:0];
	endfunction

	// Apply one accepted beat to the predicted state and return its statistics
	function automatic stats_beat_t predict_stats(logic func, logic [ID_W-1:0] id,
			logic [DATA_W-1:0] reading);
		stats_beat_t     res;
		logic [DATA_W:0] div;
		int unsigned     hd;
		res = '0;
		if (func == FUNC_UPDATE) begin
			if (!chan_seen[id]) begin
				chan_seen[id]      = 1'b1;
				chan_last[id]      = reading;
				chan_wmean[id]     = reading;
				chan_omean[id]     = reading;
				chan_count[id]     = COUNT_W'(1);
				chan_window[id][0] = reading;
				chan_head[id]      = 1 % WIN;
			end else begin
				div = {33'd0, chan_count[id]} + 1'b1;
				hd  = chan_head[id];
				chan_last[id] = reading;
				if (chan_count[id] < WIN)
					chan_wmean[id] = step_mean(chan_wmean[id], reading, chan_wmean[id], div);
				else
					chan_wmean[id] = step_mean(chan_wmean[id], reading, chan_window[id][hd],
						(DATA_W+1)'(WIN));
				chan_omean[id] = step_mean(chan_omean[id], reading, chan_omean[id], div);
				chan_window[id][hd] = reading;
				chan_head[id] = (hd + 1) % WIN;
				if (chan_count[id] != '1)
					chan_count[id] = chan_count[id] + 1'b1;
			end
		end
		if (chan_seen[id]) begin
			res.found        = 1'b1;
			res.last_value   = chan_last[id];
			res.window_mean  = chan_wmean[id];
			res.overall_mean = chan_omean[id];
			res.sample_count = chan_count[id];
		end
		return res;
	endfunction

	// Send one beat; valid stays high afterwards so a burst can follow
	task automatic send_item(logic func, logic [ID_W-1:0] id, logic [DATA_W-1:0] reading);
		in_if.valid <= 1'b1;
		in_if.data  <= {func, id, reading};
		do @(posedge clk); while (!in_if.ready);
		pending_stats.insert(pending_stats.size(), predict_stats(func, id, reading));
	endtask

	// Drop valid between bursts, unless no gap is asked for
	task automatic sender_gap(int unsigned cycles);
		if (cycles != 0) begin
			in_if.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic logic [DATA_W-1:0] rand_reading();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return DATA_MAX;
			2:       return DATA_MAX - DATA_W'($urandom_range(0, 1000));
			3, 4:    return DATA_W'($urandom_range(0, 5000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Receiver stall pattern and result check
	int unsigned stall_left;
	int unsigned run_left;
	always @(posedge clk or negedge arst_n) begin
		stats_beat_t got;
		stats_beat_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_left   <= 0;
			run_left     <= 20;
		end else begin
			// check an accepted beat against the oldest prediction
			if (out_if.valid && out_if.ready) begin
				got = out_if.data;
				if (pending_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat %h", got);
				end else begin
					want = pending_stats.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("found %b/%b last %h/%h wmean %h/%h omean %h/%h cnt %0d/%0d (exp/act)",
								want.found, got.found, want.last_value, got.last_value,
								want.window_mean, got.window_mean, want.overall_mean,
								got.overall_mean, want.sample_count, got.sample_count);
					end
				end
			end
			// alternate ready stretches with stalls of random length
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				out_if.ready <= 1'b0;
			end else if (run_left != 0) begin
				run_left     <= run_left - 1;
				out_if.ready <= 1'b1;
			end else begin
				stall_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				run_left     <= $urandom_range(1, 30);
				out_if.ready <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Reads of channels that never got a reading return zeros
	task automatic test_unknown_reads();
		send_item(FUNC_READ, 8'd0, '0);
		send_item(FUNC_READ, 8'd255, DATA_MAX);
		send_item(FUNC_READ, 8'd77, {$urandom, $urandom});
		sender_gap(3);
	endtask

	// First readings at the extremes, then read back
	task automatic test_first_update();
		send_item(FUNC_UPDATE, 8'd0, '0);
		send_item(FUNC_UPDATE, 8'd255, DATA_MAX);
		send_item(FUNC_READ, 8'd0, DATA_MAX);
		send_item(FUNC_READ, 8'd255, '0);
		sender_gap(2);
	endtask

	// Fill one window past its length with swings between the extremes
	task automatic test_window_fill();
		for (int i = 0; i < 13; i++)
			send_item(FUNC_UPDATE, 8'd5, (i % 3 == 0) ? '0 : DATA_MAX - DATA_W'(i));
		send_item(FUNC_UPDATE, 8'd255, '0);
		send_item(FUNC_UPDATE, 8'd255, DATA_MAX);
		send_item(FUNC_READ, 8'd5, '0);
		sender_gap(4);
	endtask

	// Random traffic, mostly on a few busy channels so windows wrap
	task automatic test_random_traffic(int unsigned items);
		logic [ID_W-1:0] id;
		logic            func;
		int unsigned     burst;
		int unsigned     n;
		n = 0;
		while (n < items) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < items; b++) begin
				id   = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 7))
					: ID_W'($urandom_range(0, 255));
				func = ($urandom_range(0, 99) < 30) ? FUNC_READ : FUNC_UPDATE;
				send_item(func, id, rand_reading());
				n++;
			end
			sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
		end
	endtask

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			chan_seen[c] = 1'b0;
			chan_head[c] = 0;
		end
		in_if.valid <= 1'b0;
		in_if.data  <= '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unknown_reads();
		test_first_update();
		test_window_fill();
		test_random_traffic(800);
		in_if.valid <= 1'b0;

		// drain outstanding results
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
